@@ rtl/plc_pkg.sv @@
// Shared types and codes for the positional list engine.
package plc_pkg;

  // Cell index width; covers every cell position and a count of 64
  localparam int IDX_W = 7;
  localparam int ELEM_W = 32;

  typedef enum logic [1:0] {
    REQ_REMOVE = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DUMP   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_SNAP,
    CELL_SHIFT
  } cell_op_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } cell_cmd_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } fsm_t;

endpackage

@@ rtl/positional_list_engine_core.sv @@
// Top level of the positional list engine: control and the chain of cells.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: req_type,
//   position and value. Result channel (out_valid / out_stall) carries
//   status, element, entry_count and last.
//   The list is held in a row of CAPACITY cells with the tail always in the
//   top cell. Insert and remove move every affected cell in parallel in the
//   accepting cycle; the single result word is registered and shows on the
//   next cycle. A request is thus accepted, then its result is handed off
//   before the next request is taken.
//   A dump of N elements snapshots the cells into a read-out lane, then the
//   lane shifts one cell per cycle toward the top cell, one result word per
//   cycle while the receiver does not stall, tail first: the top lane cell is
//   registered into the result word. The request channel stalls while a
//   request is in progress or a result word waits.
//   Reset (rst_n low, synchronous) empties the list and drops any result.
//   A stalled result word holds steady; a dump pauses until it is taken.
module positional_list_engine_core import plc_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_element,
  output logic [6:0]         out_entry_count,
  output logic               out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] CAP_I = IDX_W'(CAPACITY);

  fsm_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [ELEM_W-1:0] out_element_r, out_element_nxt;
  logic out_last_r, out_last_nxt;
  logic out_load;

  cell_cmd_t cmd;
  logic in_acc, out_free;
  logic [IDX_W-1:0] cnt_i, pos_i, base_i;
  logic [DATA_WIDTH-1:0] store_val;
  logic [ELEM_W-1:0] lane_elem;

  logic [DATA_WIDTH-1:0] words [CAPACITY];
  logic [DATA_WIDTH-1:0] lanes [CAPACITY];

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != FSM_IDLE) || out_valid_r;

  assign cnt_i  = IDX_W'(cnt_r);
  assign pos_i  = IDX_W'(in_position);
  assign base_i = CAP_I - cnt_i;

  // Width conversion into and out of the cells
  generate
    if (DATA_WIDTH <= ELEM_W) begin : g_st_narrow
      assign store_val = in_value[DATA_WIDTH-1:0];
    end else begin : g_st_wide
      assign store_val = {{(DATA_WIDTH-ELEM_W){in_value[ELEM_W-1]}}, in_value};
    end
    if (DATA_WIDTH >= ELEM_W) begin : g_rd_wide
      assign lane_elem = lanes[CAPACITY-1][ELEM_W-1:0];
    end else begin : g_rd_narrow
      assign lane_elem = {{(ELEM_W-DATA_WIDTH){lanes[CAPACITY-1][DATA_WIDTH-1]}},
                          lanes[CAPACITY-1]};
    end
  endgenerate

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_acc && req_t'(in_req_type) == REQ_DUMP && cnt_r != '0) begin
          state_nxt = FSM_DUMP;
        end
      end
      FSM_DUMP: begin
        if (out_free && rem_r == CNT_W'(1)) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Cell commands, count and result word
  always_comb begin
    cmd             = '{op: CELL_HOLD, lo: '0, hi: '0};
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    out_load        = 1'b0;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          out_load        = 1'b1;
          out_status_nxt  = ST_OK;
          out_element_nxt = '0;
          out_last_nxt    = 1'b1;
          case (req_t'(in_req_type))
            REQ_REMOVE: begin
              if (cnt_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (pos_i >= cnt_i) begin
                out_status_nxt = ST_BADPOS;
              end else begin
                cmd     = '{op: CELL_REM, lo: base_i, hi: base_i + pos_i};
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            REQ_INSERT: begin
              if (pos_i > cnt_i) begin
                out_status_nxt = ST_BADPOS;
              end else if (cnt_i >= CAP_I) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd = '{op: CELL_INS, lo: base_i - IDX_W'(1),
                        hi: base_i - IDX_W'(1) + pos_i};
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            REQ_DUMP: begin
              if (cnt_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // First word comes from the lane on the following cycles
                out_load = 1'b0;
                cmd.op   = CELL_SNAP;
                rem_nxt  = cnt_r;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_DUMP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_nxt  = ST_OK;
          out_element_nxt = lane_elem;
          out_last_nxt    = (rem_r == CNT_W'(1));
          cmd.op          = CELL_SHIFT;
          rem_nxt         = rem_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= out_status_nxt;
      out_element_r <= out_element_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  // Chain of cells
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] up_w, dn_w, dn_l;
      if (gi == CAPACITY - 1) begin : g_top
        assign up_w = '0;
      end else begin : g_mid
        assign up_w = words[gi+1];
      end
      if (gi == 0) begin : g_bot
        assign dn_w = '0;
        assign dn_l = '0;
      end else begin : g_up
        assign dn_w = words[gi-1];
        assign dn_l = lanes[gi-1];
      end
      plc_cell #(
        .DATA_WIDTH(DATA_WIDTH),
        .IDX       (gi)
      ) u_cell (
        .clk    (clk),
        .cmd    (cmd),
        .value  (store_val),
        .up_word(up_w),
        .dn_word(dn_w),
        .dn_lane(dn_l),
        .word_o (words[gi]),
        .lane_o (lanes[gi])
      );
    end
  endgenerate

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element     = out_element_r;
  assign out_entry_count = 7'(cnt_r);
  assign out_last        = out_last_r;

endmodule

@@ rtl/plc_cell.sv @@
// One list cell: a stored word and a read-out lane word.
module plc_cell import plc_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] up_word,
  input  logic [DATA_WIDTH-1:0] dn_word,
  input  logic [DATA_WIDTH-1:0] dn_lane,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic [DATA_WIDTH-1:0] lane_o
);

  localparam logic [IDX_W-1:0] POS = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [DATA_WIDTH-1:0] lane_r, lane_nxt;

  // List is top aligned: insert moves lower cells down, remove moves them up
  always_comb begin
    word_nxt = word_r;
    lane_nxt = lane_r;
    case (cmd.op)
      CELL_INS: begin
        if (POS >= cmd.lo && POS < cmd.hi) word_nxt = up_word;
        else if (POS == cmd.hi) word_nxt = value;
      end
      CELL_REM: begin
        if (POS >= cmd.lo && POS <= cmd.hi) word_nxt = dn_word;
      end
      CELL_SNAP:  lane_nxt = word_r;
      CELL_SHIFT: lane_nxt = dn_lane;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    lane_r <= lane_nxt;
  end

  assign word_o = word_r;
  assign lane_o = lane_r;

endmodule

@@ rtl/plc_checker.sv @@
// Port-level checks for the positional list engine, bound to the top level.
module plc_checker import plc_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_element,
  input logic [6:0]  out_entry_count,
  input logic        out_last
);

  // A waiting result word holds steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element) && $stable(out_last))
    else $error("result word changed while stalled");

  // No request is taken while a result word waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");

  // Count shown with a result word never exceeds the number of cells
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 7'(CAPACITY))
    else $error("entry count above capacity");

  // Only dump words of a nonempty list come without last, and they are ok
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> status_t'(out_status) == ST_OK)
    else $error("error status on a non-final word");

  // Error results carry no element
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_t'(out_status) != ST_OK |-> out_element == '0)
    else $error("error status with nonzero element");

endmodule

bind positional_list_engine_core plc_checker #(.CAPACITY(CAPACITY)) u_plc_checker (.*);

@@ tb/plc_list_sb_pkg.sv @@
// Scoreboard for the positional list engine: list predictor and result check.
`timescale 1ns / 1ps
package plc_list_sb_pkg;
  import plc_pkg::*;

  localparam int LIST_CAPACITY = 32;

  // One expected result word
  typedef struct {
    status_t     status;
    logic [31:0] element;
    logic [6:0]  entry_count;
    logic        last_flag;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] held_words[$];
    list_result_t       pending_results[$];
    int unsigned        fail_count;

    function new();
      fail_count = 0;
    endfunction

    function int unsigned held_count();
      return held_words.size();
    endfunction

    function void push_result(status_t st, logic [31:0] elem, int unsigned cnt, bit fin);
      list_result_t r;
      r.status      = st;
      r.element     = elem;
      r.entry_count = cnt[6:0];
      r.last_flag   = fin;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted request word to the list and queue its results
    function void note_request(req_t req, logic [5:0] pos, logic signed [31:0] val);
      int unsigned n;
      n = held_words.size();
      case (req)
        REQ_REMOVE: begin
          if (n == 0) begin
            push_result(ST_EMPTY, '0, n, 1'b1);
          end else if (pos >= n) begin
            push_result(ST_BADPOS, '0, n, 1'b1);
          end else begin
            held_words.delete(pos);
            push_result(ST_OK, '0, n - 1, 1'b1);
          end
        end
        REQ_INSERT: begin
          // position check wins over the full check
          if (pos > n) begin
            push_result(ST_BADPOS, '0, n, 1'b1);
          end else if (n >= LIST_CAPACITY) begin
            push_result(ST_FULL, '0, n, 1'b1);
          end else begin
            held_words.insert(pos, val);
            push_result(ST_OK, '0, n + 1, 1'b1);
          end
        end
        REQ_DUMP: begin
          if (n == 0) begin
            push_result(ST_EMPTY, '0, 0, 1'b1);
          end else begin
            // tail first, head last
            for (int i = n; i > 0; i--) begin
              push_result(ST_OK, held_words[i-1], n, i == 1);
            end
          end
        end
        default: begin
          push_result(ST_OK, '0, n, 1'b1);
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(logic [1:0] st, logic signed [31:0] elem, logic [6:0] cnt,
                               logic fin);
      list_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0d element %0d count %0d last %0d",
                 $time, st, elem, cnt, fin);
        fail_count++;
        return;
      end
      r = pending_results.pop_front();
      if (st !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
        fail_count++;
      end
      if (elem !== r.element) begin
        $display("%0t: element expected %0d actual %0d", $time,
                 $signed(r.element), elem);
        fail_count++;
      end
      if (cnt !== r.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, r.entry_count, cnt);
        fail_count++;
      end
      if (fin !== r.last_flag) begin
        $display("%0t: last expected %0d actual %0d", $time, r.last_flag, fin);
        fail_count++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb_positional_list_engine_core.sv @@
// Testbench top for the positional list engine: directed and random requests.
`timescale 1ns / 1ps
module tb_positional_list_engine_core;
  import plc_pkg::*;
  import plc_list_sb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_req_type;
  logic [5:0]         in_position;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic signed [31:0] out_element;
  logic [6:0]         out_entry_count;
  logic               out_last;

  bit                 idle_en;
  int unsigned        cycle_count;
  list_scoreboard     sb = new();

  positional_list_engine_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_element    (out_element),
    .out_entry_count(out_entry_count),
    .out_last       (out_last)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("positional_list_engine_core verification failed");
    $finish;
  end

  // Result side: take words, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_status, out_element, out_entry_count, out_last);
      end
      if (!idle_en) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Random words, with the extremes mixed in half the time
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Present one request word, hold it until taken, then maybe pause
  task automatic drive_request(req_t req, logic [5:0] pos, logic signed [31:0] val);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_value    <= val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(req, pos, val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Random requests; percentages pick insert, remove, dump, the rest is noise
  task automatic run_phase(int items, int ins_pct, int rem_pct, int dump_pct);
    int unsigned n;
    int unsigned roll;
    for (int k = 0; k < items; k++) begin
      n = sb.held_count();
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        drive_request(REQ_INSERT, 6'($urandom_range(0, n)), pick_word());
      end else if (roll < ins_pct + rem_pct) begin
        drive_request(REQ_REMOVE, (n == 0) ? 6'd0 : 6'($urandom_range(0, n - 1)),
                      pick_word());
      end else if (roll < ins_pct + rem_pct + dump_pct) begin
        drive_request(REQ_DUMP, 6'($urandom_range(0, 63)), pick_word());
      end else begin
        drive_request(req_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                      pick_word());
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_NONE;
    in_position <= '0;
    in_value    <= '0;
    idle_en     <= 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list corners
    drive_request(REQ_DUMP,   6'd0,  32'h1234_5678);
    drive_request(REQ_REMOVE, 6'd0,  32'h0);
    drive_request(REQ_REMOVE, 6'd63, 32'hFFFF_FFFF);
    drive_request(REQ_INSERT, 6'd1,  32'h5555_5555);
    // Head, append, head again, middle
    drive_request(REQ_INSERT, 6'd0,  32'h7FFF_FFFF);
    drive_request(REQ_INSERT, 6'd1,  32'h8000_0000);
    drive_request(REQ_INSERT, 6'd0,  32'h0000_0000);
    drive_request(REQ_INSERT, 6'd1,  32'hFFFF_FFFF);
    drive_request(REQ_NONE,   6'd63, 32'hA5A5_A5A5);
    drive_request(REQ_DUMP,   6'd63, 32'h0);
    // Positions past the end
    drive_request(REQ_INSERT, 6'd63, 32'h1);
    drive_request(REQ_INSERT, 6'd5,  32'h2);
    drive_request(REQ_REMOVE, 6'd4,  32'h0);
    drive_request(REQ_REMOVE, 6'd63, 32'h0);
    // Remove tail, head, middle
    drive_request(REQ_REMOVE, 6'd3,  32'h0);
    drive_request(REQ_REMOVE, 6'd0,  32'h0);
    drive_request(REQ_INSERT, 6'd1,  32'h5A5A_5A5A);
    drive_request(REQ_REMOVE, 6'd1,  32'h0);
    drive_request(REQ_DUMP,   6'd0,  32'h0);
    drive_request(REQ_REMOVE, 6'd0,  32'h0);
    drive_request(REQ_REMOVE, 6'd0,  32'h0);
    drive_request(REQ_DUMP,   6'd0,  32'h0);

    // Grow until full, drain until empty, then mix
    run_phase(80, 80, 7, 8);
    run_phase(80, 10, 70, 10);
    run_phase(80, 40, 35, 15);
    idle_en <= 1'b0;
    run_phase(30, 40, 35, 15);
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
      $display("positional_list_engine_core verification clean");
    end else begin
      $display("positional_list_engine_core verification failed");
    end
    $finish;
  end

endmodule
